>>> hdl/pagc_pkg.sv
// Shared constants and types for the peak AGC gain stage.
package pagc_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int GAIN_W     = 24;
   localparam int COEFF_W    = 16;
   localparam int FRAC_GAIN  = 19;
   localparam int FRAC_COEFF = 16;

   localparam int FADE_STEPS = 1024;
   localparam int FADE_SH    = $clog2(FADE_STEPS);
   localparam int FADE_W     = $clog2(FADE_STEPS + 1);

   localparam int RAMP_STEPS = 512;
   localparam int RAMP_SH    = $clog2(RAMP_STEPS);
   localparam int RAMP_W     = $clog2(RAMP_STEPS + 1);
   localparam int RAMP_INC_W = SAMPLE_W + 1 - RAMP_SH;

   localparam int DIV_QBITS  = 24;
   localparam int DIV_NUM_W  = GAIN_W + FRAC_GAIN;
   localparam int DIV_CNT_W  = $clog2(DIV_QBITS + 1);

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd524288;

   localparam logic [23:0] RST_TARGET_PEAK = 24'd4194304;
   localparam logic [15:0] RST_ATTACK      = 16'd6554;
   localparam logic [15:0] RST_RELEASE     = 16'd66;
   localparam logic [15:0] RST_HOLD        = 16'd1920;
   localparam logic [15:0] RST_SMOOTH      = 16'd328;
   localparam logic [23:0] RST_NOISE_FLOOR = 24'd8389;
   localparam logic [23:0] RST_MAX_GAIN    = 24'd8388608;

   typedef enum logic [2:0] {
      REG_TARGET_PEAK  = 3'd0,
      REG_SQUASH_EN    = 3'd1,
      REG_ATTACK       = 3'd2,
      REG_RELEASE      = 3'd3,
      REG_HOLD         = 3'd4,
      REG_SMOOTH       = 3'd5,
      REG_NOISE_FLOOR  = 3'd6,
      REG_MAX_GAIN     = 3'd7
   } csr_index_type;

endpackage

>>> hdl/pagc_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
module pagc_div
   import pagc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [GAIN_W-1:0]    divisor,
   output logic                 busy,
   output logic [DIV_QBITS-1:0] quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [GAIN_W-1:0]    rem_ff, rem_in;
   logic [DIV_QBITS-1:0] low_ff, quo_ff;
   logic                 ovf_ff;
   logic [GAIN_W:0]      trial, trial_sub;
   logic                 trial_ge;
   logic [GAIN_W-1:0]    top_part;

   assign top_part  = GAIN_W'(dividend[DIV_NUM_W-1:DIV_QBITS]);
   assign trial     = {rem_ff, low_ff[DIV_QBITS-1]};
   assign trial_ge  = trial >= {1'b0, divisor};
   assign trial_sub = trial - {1'b0, divisor};
   assign rem_in    = trial_ge ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(DIV_QBITS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= top_part;
         low_ff <= dividend[DIV_QBITS-1:0];
         ovf_ff <= top_part >= divisor;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[DIV_QBITS-2:0], 1'b0};
         quo_ff <= {quo_ff[DIV_QBITS-2:0], trial_ge};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = ovf_ff ? '1 : quo_ff;

endmodule

>>> hdl/peak_agc_gain_stage.sv
// Top level of the peak-envelope AGC gain stage.
// An accepted req word steps through envelope update, two divisions, fade mix, gain smoothing
// and the left and right products before rsp_tvalid; req_tready is high only when the sequencer idles.
// The two 24-step divisions (lower clamp, target over envelope) take most of the time per word.
// A finished word waits in the output register; the next may be accepted meanwhile.
// Synchronous active-high reset restores register defaults and unity gain.
module peak_agc_gain_stage
   import pagc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // left_sample, right_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // left_out, right_out, applied_gain
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_ENV_MUL   = 15'b000000000000010,
      ST_ENV_UPD   = 15'b000000000000100,
      ST_LO_START  = 15'b000000000001000,
      ST_LO_WAIT   = 15'b000000000010000,
      ST_RAW_START = 15'b000000000100000,
      ST_RAW_WAIT  = 15'b000000001000000,
      ST_RAW_SET   = 15'b000000010000000,
      ST_MIX_MUL   = 15'b000000100000000,
      ST_MIX_SET   = 15'b000001000000000,
      ST_SM_MUL    = 15'b000010000000000,
      ST_SM_UPD    = 15'b000100000000000,
      ST_OUT_L     = 15'b001000000000000,
      ST_OUT_R     = 15'b010000000000000,
      ST_DONE      = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [23:0]        target_ff;
   logic               squash_ff;
   logic [15:0]        attack_ff, release_ff, hold_cfg_ff, smooth_ff;
   logic [23:0]        noise_ff, max_gain_ff;

   // running state
   logic [23:0]           env_ff;
   logic [15:0]           hold_ff;
   logic [FADE_W-1:0]     mix_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [23:0]           ramped_ff;
   logic [RAMP_W-1:0]     steps_ff;
   logic signed [RAMP_INC_W-1:0] inc_ff;

   // per-word payload
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic [23:0]           peak_ff;
   logic                  att_ff;
   logic [GAIN_W-1:0]     lo_ff, raw_ff, g_ff;
   logic                  g_lt_ff;
   logic [SAMPLE_W-1:0]   lout_ff;
   logic signed [49:0]    mul_p_ff;
   logic                  rsp_valid_ff;
   logic [71:0]           rsp_data_ff;

   // combinational
   logic signed [SAMPLE_W-1:0] in_l, in_r;
   logic [23:0]           abs_l, abs_r;
   logic signed [24:0]    tgt_diff, tgt_adj;
   logic signed [24:0]    mul_a, mul_b;
   logic signed [49:0]    mul_p;
   logic                  mul_en;
   logic                  att;
   logic [23:0]           env_diff, sm_diff;
   logic [15:0]           env_coeff;
   logic                  div_start, div_busy;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [GAIN_W-1:0]     div_den;
   logic [DIV_QBITS-1:0]  div_q;
   logic [GAIN_W-1:0]     raw_clamp;
   logic [FADE_W-1:0]     mix_next, fade_left;
   logic [34:0]           mix_sum;
   logic [SAMPLE_W-1:0]   sat_out;
   logic                  accept, out_free;

   assign in_l   = req_tdata[23:0];
   assign in_r   = req_tdata[47:24];
   assign abs_l  = in_l[23] ? (~in_l + 1'b1) : in_l;
   assign abs_r  = in_r[23] ? (~in_r + 1'b1) : in_r;
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // target ramp increment, truncated toward zero
   assign tgt_diff = $signed({1'b0, csr_wdata}) - $signed({1'b0, ramped_ff});
   assign tgt_adj  = tgt_diff + (tgt_diff[24] ? 25'(RAMP_STEPS - 1) : 25'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= RST_TARGET_PEAK;
         squash_ff   <= 1'b0;
         attack_ff   <= RST_ATTACK;
         release_ff  <= RST_RELEASE;
         hold_cfg_ff <= RST_HOLD;
         smooth_ff   <= RST_SMOOTH;
         noise_ff    <= RST_NOISE_FLOOR;
         max_gain_ff <= RST_MAX_GAIN;
         ramped_ff   <= RST_TARGET_PEAK;
         steps_ff    <= '0;
         inc_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            REG_TARGET_PEAK: begin
               if (csr_wdata != target_ff) begin
                  target_ff <= csr_wdata;
                  steps_ff  <= RAMP_W'(RAMP_STEPS);
                  inc_ff    <= tgt_adj[24:RAMP_SH];
               end
            end
            REG_SQUASH_EN:   squash_ff   <= csr_wdata[0];
            REG_ATTACK:      attack_ff   <= csr_wdata[15:0];
            REG_RELEASE:     release_ff  <= csr_wdata[15:0];
            REG_HOLD:        hold_cfg_ff <= csr_wdata[15:0];
            REG_SMOOTH:      smooth_ff   <= csr_wdata[15:0];
            REG_NOISE_FLOOR: noise_ff    <= csr_wdata;
            REG_MAX_GAIN:    max_gain_ff <= csr_wdata;
            default: ;
         endcase
      end else if (accept && steps_ff != '0) begin
         steps_ff <= steps_ff - 1'b1;
         if (steps_ff == RAMP_W'(1)) begin
            ramped_ff <= target_ff;
         end else begin
            ramped_ff <= ramped_ff + 24'(inc_ff);
         end
      end
   end

   // shared multiplier operands
   assign att       = peak_ff > env_ff;
   assign env_diff  = att ? peak_ff - env_ff : env_ff - peak_ff;
   assign env_coeff = att ? attack_ff : release_ff;
   assign sm_diff   = g_ff - gain_ff;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      unique case (state_ff)
         ST_ENV_MUL: begin
            mul_a  = $signed(25'(env_coeff));
            mul_b  = $signed({1'b0, env_diff});
            mul_en = 1'b1;
         end
         ST_MIX_MUL: begin
            mul_a  = $signed({1'b0, raw_ff});
            mul_b  = $signed(25'(mix_ff));
            mul_en = 1'b1;
         end
         ST_SM_MUL: begin
            mul_a  = $signed(25'(smooth_ff));
            mul_b  = $signed({1'b0, sm_diff});
            mul_en = 1'b1;
         end
         ST_OUT_L: begin
            mul_a  = 25'(left_ff);
            mul_b  = $signed({1'b0, gain_ff});
            mul_en = 1'b1;
         end
         ST_OUT_R: begin
            mul_a  = 25'(right_ff);
            mul_b  = $signed({1'b0, gain_ff});
            mul_en = 1'b1;
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // floor shift by 2^19 and saturate
   always_comb begin
      if (mul_p_ff[49:42] == '0 || mul_p_ff[49:42] == '1) begin
         sat_out = mul_p_ff[42:19];
      end else if (mul_p_ff[49]) begin
         sat_out = 24'h800000;
      end else begin
         sat_out = 24'h7FFFFF;
      end
   end

   // divisor held for the whole division
   assign div_start = state_ff == ST_LO_START || state_ff == ST_RAW_START;
   assign div_num   = (state_ff == ST_LO_START) ? DIV_NUM_W'(1) << 38
                                                : {ramped_ff, FRAC_GAIN'(0)};
   assign div_den   = (state_ff == ST_LO_START || state_ff == ST_LO_WAIT) ? max_gain_ff
                                                                          : env_ff;

   pagc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign raw_clamp = (div_q > max_gain_ff) ? max_gain_ff : div_q;

   always_comb begin
      mix_next = mix_ff;
      if (squash_ff) begin
         if (mix_ff < FADE_W'(FADE_STEPS)) mix_next = mix_ff + 1'b1;
      end else begin
         if (mix_ff != '0) mix_next = mix_ff - 1'b1;
      end
   end

   assign fade_left = FADE_W'(FADE_STEPS) - mix_ff;
   assign mix_sum   = {5'b0, fade_left, 19'b0} + mul_p_ff[34:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_ENV_MUL;
         ST_ENV_MUL:   state_in = ST_ENV_UPD;
         ST_ENV_UPD:   state_in = ST_LO_START;
         ST_LO_START:  state_in = ST_LO_WAIT;
         ST_LO_WAIT:   if (!div_busy) state_in = ST_RAW_START;
         ST_RAW_START: state_in = ST_RAW_WAIT;
         ST_RAW_WAIT:  if (!div_busy) state_in = ST_RAW_SET;
         ST_RAW_SET:   state_in = ST_MIX_MUL;
         ST_MIX_MUL:   state_in = ST_MIX_SET;
         ST_MIX_SET:   state_in = ST_SM_MUL;
         ST_SM_MUL:    state_in = ST_SM_UPD;
         ST_SM_UPD:    state_in = ST_OUT_L;
         ST_OUT_L:     state_in = ST_OUT_R;
         ST_OUT_R:     state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         hold_ff      <= '0;
         mix_ff       <= '0;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_ENV_UPD: begin
               if (att_ff) begin
                  env_ff  <= env_ff + mul_p_ff[39:16];
                  hold_ff <= hold_cfg_ff;
               end else if (hold_ff != '0) begin
                  hold_ff <= hold_ff - 1'b1;
               end else begin
                  env_ff  <= env_ff - mul_p_ff[39:16];
               end
            end
            ST_RAW_SET: mix_ff <= mix_next;
            ST_SM_UPD: begin
               if (g_lt_ff) begin
                  gain_ff <= g_ff;
               end else begin
                  gain_ff <= gain_ff + mul_p_ff[39:16];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) mul_p_ff <= mul_p;
      if (accept) begin
         left_ff  <= in_l;
         right_ff <= in_r;
         peak_ff  <= (abs_l > abs_r) ? abs_l : abs_r;
      end
      if (state_ff == ST_ENV_MUL) att_ff <= att;
      if (state_ff == ST_LO_WAIT && !div_busy) lo_ff <= div_q;
      if (state_ff == ST_RAW_SET) begin
         if (env_ff <= noise_ff) begin
            raw_ff <= UNITY_GAIN;
         end else begin
            raw_ff <= (raw_clamp < lo_ff) ? lo_ff : raw_clamp;
         end
      end
      if (state_ff == ST_MIX_SET) g_ff <= mix_sum[FADE_SH +: GAIN_W];
      if (state_ff == ST_SM_MUL) g_lt_ff <= g_ff < gain_ff;
      if (state_ff == ST_OUT_R) lout_ff <= sat_out;
      if (state_ff == ST_DONE && out_free) rsp_data_ff <= {gain_ff, sat_out, lout_ff};
   end

endmodule

>>> hdl/pagc_chk.sv
// Port-level checks for the peak AGC gain stage, bound to the top level.
module pagc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        csr_we,
   input logic [2:0]  csr_addr,
   input logic [23:0] csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted twice in a row");

   a_new_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("rsp word raised while still busy");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind peak_agc_gain_stage pagc_chk u_pagc_chk (.*);

>>> bench/peak_agc_gain_stage_tb.sv
// Self-checking bench for the peak AGC gain stage: predicted gain and output words.
module peak_agc_gain_stage_tb;
   import pagc_pkg::*;

   typedef struct packed {
      logic [23:0] gain;
      logic [23:0] right;
      logic [23:0] left;
   } agc_word_t;

   class agc_scoreboard;
      logic [23:0] target_peak, max_gain, noise_floor;
      logic        squash_en;
      logic [15:0] attack, release_c, hold, smooth;
      logic [23:0] envelope, ramped_target, smoothed_gain;
      logic [15:0] hold_left;
      int          enable_mix, ramp_left;
      longint      ramp_inc;
      agc_word_t   pending[$];
      int          mismatches, checked;

      function void clear();
         target_peak = RST_TARGET_PEAK; squash_en = 0; attack = RST_ATTACK;
         release_c = RST_RELEASE; hold = RST_HOLD; smooth = RST_SMOOTH;
         noise_floor = RST_NOISE_FLOOR; max_gain = RST_MAX_GAIN;
         envelope = 0; hold_left = 0; enable_mix = 0; smoothed_gain = UNITY_GAIN;
         ramped_target = RST_TARGET_PEAK; ramp_left = 0; ramp_inc = 0;
         mismatches = 0; checked = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [23:0] v);
         case (idx)
            REG_TARGET_PEAK: if (v != target_peak) begin
               target_peak = v;
               ramp_left = RAMP_STEPS;
               ramp_inc = (longint'(v) - longint'(ramped_target)) / RAMP_STEPS;
            end
            REG_SQUASH_EN:   squash_en = v[0];
            REG_ATTACK:      attack = v[15:0];
            REG_RELEASE:     release_c = v[15:0];
            REG_HOLD:        hold = v[15:0];
            REG_SMOOTH:      smooth = v[15:0];
            REG_NOISE_FLOOR: noise_floor = v;
            REG_MAX_GAIN:    max_gain = v;
            default: ;
         endcase
      endfunction

      function logic [23:0] scale(longint s, longint g);
         longint p, q;
         p = s * g;
         q = p >= 0 ? (p >>> 19) : -((-p + 524287) >>> 19);
         if (q > 8388607) q = 8388607;
         if (q < -8388608) q = -8388608;
         return q[23:0];
      endfunction

      function void note_sample(logic signed [23:0] l, logic signed [23:0] r);
         longint al, ar, a, raw, lo, g;
         agc_word_t w;
         al = l < 0 ? -longint'(l) : longint'(l);
         ar = r < 0 ? -longint'(r) : longint'(r);
         a = al > ar ? al : ar;
         if (ramp_left > 0) begin
            ramp_left--;
            if (ramp_left == 0) ramped_target = target_peak;
            else ramped_target = 24'(longint'(ramped_target) + ramp_inc);
         end
         if (a > envelope) begin
            envelope = 24'(longint'(envelope) + ((longint'(attack) * (a - envelope)) >>> 16));
            hold_left = hold;
         end else if (hold_left > 0) hold_left--;
         else envelope = 24'(longint'(envelope)
                             - ((longint'(release_c) * (longint'(envelope) - a)) >>> 16));
         raw = UNITY_GAIN;
         if (envelope > noise_floor) begin
            lo = max_gain != 0 ? (64'd1 << 38) / max_gain : 64'hFFFFFF;
            if (lo > 64'hFFFFFF) lo = 64'hFFFFFF;
            raw = (longint'(ramped_target) << 19) / envelope;
            if (raw > max_gain) raw = max_gain;
            if (raw < lo) raw = lo;
         end
         if (squash_en) begin
            if (enable_mix < FADE_STEPS) enable_mix++;
         end else if (enable_mix > 0) enable_mix--;
         g = (longint'(UNITY_GAIN) * (FADE_STEPS - enable_mix) + raw * enable_mix) / FADE_STEPS;
         if (g < smoothed_gain) smoothed_gain = g[23:0];
         else smoothed_gain = 24'(longint'(smoothed_gain)
                                  + ((longint'(smooth) * (g - smoothed_gain)) >>> 16));
         w.left = scale(l, smoothed_gain);
         w.right = scale(r, smoothed_gain);
         w.gain = smoothed_gain;
         pending.push_back(w);
      endfunction

      function void check_word(agc_word_t got);
         agc_word_t exp_w;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
            return;
         end
         exp_w = pending.pop_front();
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch #%0d: exp L %h R %h G %h, got L %h R %h G %h",
                        checked, exp_w.left, exp_w.right, exp_w.gain,
                        got.left, got.right, got.gain);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [47:0] req_tdata = 0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = 0;
   logic [23:0] csr_wdata = 0;

   agc_scoreboard sb = new();
   int idle_cycles = 0, samples_sent = 0;
   bit rsp_stall_on = 1;

   peak_agc_gain_stage DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
         $display("watchdog expired");
         $display("peak_agc_gain_stage_tb failed");
         $finish;
      end
   end

   // receiver: random stall per word
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = rsp_stall_on ? $urandom_range(0, 12) : 0;
         if (n != 0) begin
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_sample(logic signed [23:0] l, logic signed [23:0] r, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 12) : 0;
      repeat (n) @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {r, l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(l, r);
      samples_sent++;
      @(negedge clock);
      req_tvalid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [23:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   function automatic logic [23:0] level(int pick);
      case (pick)
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'($urandom_range(0, 255));
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic random_phase(int count, bit gaps);
      logic [23:0] l, amp;
      for (int i = 0; i < count; i++) begin
         amp = $urandom_range(0, 3) == 0 ? 24'($urandom())
                                         : 24'($urandom() >> $urandom_range(2, 14));
         l = $urandom_range(0, 1) ? amp : -amp;
         if ($urandom_range(0, 9) == 0) l = level($urandom_range(0, 4));
         if ($urandom_range(0, 2) == 0) send_sample(l, l, gaps);
         else send_sample(l, $urandom_range(0, 7) == 0 ? level($urandom_range(0, 4))
                                                       : l ^ 24'($urandom_range(0, 4095)), gaps);
      end
   endtask

   initial begin
      sb.clear();
      repeat (6) @(negedge clock);
      reset <= 0;
      // directed: extremes at reset settings, then enabled with fast dynamics
      send_sample(24'h800000, 24'h7FFFFF, 0);
      send_sample(24'h7FFFFF, 24'h800000, 1);
      send_sample(24'h000000, 24'h000000, 1);
      send_sample(24'hFFFFFF, 24'h000001, 1);
      drain();
      write_csr(REG_SQUASH_EN, 1);
      write_csr(REG_ATTACK, 16'hFFFF);
      write_csr(REG_HOLD, 0);
      write_csr(REG_RELEASE, 16'hFFFF);
      write_csr(REG_SMOOTH, 16'hFFFF);
      write_csr(REG_MAX_GAIN, 24'hFFFFFF);
      write_csr(REG_NOISE_FLOOR, 0);
      write_csr(REG_TARGET_PEAK, 24'h800000);
      write_csr(REG_TARGET_PEAK, 24'h800000);
      send_sample(24'h000010, 24'h000010, 0);
      send_sample(24'h000001, 24'hFFFFFF, 1);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 1);
      send_sample(24'h400000, 24'hC00000, 1);
      drain();
      write_csr(REG_MAX_GAIN, 0);         // lower clamp saturates
      send_sample(24'h100000, 24'h100000, 1);
      drain();
      write_csr(REG_MAX_GAIN, 24'd1000);  // clamps cross
      send_sample(24'h100000, 24'hF00000, 1);
      drain();
      write_csr(REG_MAX_GAIN, 24'd524288);
      write_csr(REG_TARGET_PEAK, 0);
      send_sample(24'h200000, 24'h200000, 1);
      send_sample(24'h000000, 24'h000000, 1);
      drain();
      // sender held until all words have returned (pause above)
      write_csr(REG_TARGET_PEAK, 24'h200000);
      write_csr(REG_ATTACK, 16'd6554);
      write_csr(REG_RELEASE, 16'd2000);
      write_csr(REG_HOLD, 16'd8);
      write_csr(REG_SMOOTH, 16'd4000);
      write_csr(REG_NOISE_FLOOR, 24'd8389);
      write_csr(REG_MAX_GAIN, 24'd8388608);
      random_phase(300, 1);
      drain();
      rsp_stall_on = 0;
      write_csr(REG_TARGET_PEAK, 24'($urandom()));
      write_csr(REG_ATTACK, 24'($urandom()));
      write_csr(REG_RELEASE, 24'($urandom()));
      write_csr(REG_HOLD, 24'($urandom_range(0, 40)));
      write_csr(REG_SMOOTH, 24'($urandom()));
      write_csr(REG_NOISE_FLOOR, 24'($urandom() >> 4));
      write_csr(REG_MAX_GAIN, 24'($urandom()));
      random_phase(300, 0);
      drain();
      rsp_stall_on = 1;
      write_csr(REG_SQUASH_EN, 0);
      write_csr(REG_TARGET_PEAK, 24'h7FFFFF);
      random_phase(300, 1);
      drain();
      $display("covered %0d sample words over directed clamp and ramp cases", samples_sent);
      $display("and three random phases; %0d words checked", sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("peak_agc_gain_stage_tb passed");
      else
         $display("peak_agc_gain_stage_tb failed");
      $finish;
   end
endmodule
